// ===== src/dpt_pkg.sv =====
// Shared types and constants of the demand paging page table.
`timescale 1ns / 1ps
package dpt_pkg;

    // Field widths of the channels
    localparam int PID_W    = 5;
    localparam int PAGE_W   = 6;
    localparam int NPROC_W  = 6;
    localparam int FRAME_W  = 8;
    localparam int USE_W    = 8;
    localparam int FAULT_W  = 7;
    localparam int REF_W    = 16;
    localparam int FREE_W   = 9;
    localparam int STATUS_W = 2;

    // Each configured process owns eight page-table frames
    localparam int FRAMES_SHIFT = 3;

    localparam logic [FAULT_W-1:0] FAULT_MAX = '1;
    localparam logic [REF_W-1:0]   REF_MAX   = '1;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT   = 2'd0,
        ST_FAULT = 2'd1,
        ST_OOM   = 2'd2
    } t_status;

    // One page table entry
    typedef struct packed {
        logic               valid;
        logic [FRAME_W-1:0] frame;
        logic [USE_W-1:0]   uses;
    } t_entry;

    // Per-process statistics
    typedef struct packed {
        logic [FAULT_W-1:0] faults;
        logic [REF_W-1:0]   refs;
    } t_counts;

    // Outcome of one lookup
    typedef struct packed {
        t_status            status;
        logic [FRAME_W-1:0] frame;
        logic [USE_W-1:0]   uses;
        t_entry             entry;
        t_counts            counts;
        logic               entry_we;
        logic               cnt_we;
        logic               alloc;
        logic               halt_set;
    } t_update;

endpackage

// ===== src/dpt_in_if.sv =====
// Reference request channel: process and virtual page.
`timescale 1ns / 1ps
interface dpt_in_if;
    import dpt_pkg::*;

    logic              valid;
    logic              ready;
    logic [PID_W-1:0]  process_id;
    logic [PAGE_W-1:0] virtual_page;

    modport source (output valid, output process_id, output virtual_page, input ready);
    modport sink   (input valid, input process_id, input virtual_page, output ready);
endinterface

// ===== src/dpt_out_if.sv =====
// Lookup result channel.
`timescale 1ns / 1ps
interface dpt_out_if;
    import dpt_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [FRAME_W-1:0]  frame_number;
    logic [USE_W-1:0]    use_count;
    logic [FAULT_W-1:0]  process_faults;
    logic [REF_W-1:0]    process_references;

    modport source (output valid, output status, output frame_number, output use_count,
                    output process_faults, output process_references, input ready);
    modport sink   (input valid, input status, input frame_number, input use_count,
                    input process_faults, input process_references, output ready);
endinterface

// ===== src/dpt_cfg_if.sv =====
// Configuration write channel carrying num_processes.
`timescale 1ns / 1ps
interface dpt_cfg_if;
    import dpt_pkg::*;

    logic               valid;
    logic               ready;
    logic [NPROC_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/dpt_ram.sv =====
// Generic single-clock RAM, one write port and one registered read port.
`timescale 1ns / 1ps
module dpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_re,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write, and read through a register; hold read data when not enabled
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_re) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/dpt_update.sv =====
// Modify step: hit, fault allocation or out-of-memory decision for one entry.
`timescale 1ns / 1ps
module dpt_update
    import dpt_pkg::*;
#(
    parameter int TOTAL_FRAMES = 256
) (
    input  logic              i_halted,
    input  logic [FREE_W-1:0] i_next_free,
    input  t_entry            i_entry,
    input  t_counts           i_counts,
    output t_update           o_upd
);

    logic    oom;
    t_counts counts_inc;

    // Out of memory once halted, or on a miss with no frame left
    assign oom = i_halted ||
                 (!i_entry.valid && (i_next_free >= FREE_W'(TOTAL_FRAMES)));

    // Saturating statistics
    always_comb begin
        counts_inc.refs   = (i_counts.refs == REF_MAX) ? i_counts.refs
                                                       : i_counts.refs + 1'b1;
        counts_inc.faults = i_counts.faults;
        if (!i_entry.valid && (i_counts.faults != FAULT_MAX)) begin
            counts_inc.faults = i_counts.faults + 1'b1;
        end
    end

    // Pick the outcome
    always_comb begin
        o_upd          = '0;
        o_upd.counts   = i_counts;
        o_upd.halt_set = oom && !i_halted;
        if (oom) begin
            o_upd.status = ST_OOM;
        end else if (i_entry.valid) begin
            o_upd.status       = ST_HIT;
            o_upd.entry.valid  = 1'b1;
            o_upd.entry.frame  = i_entry.frame;
            o_upd.entry.uses   = i_entry.uses + 1'b1;
            o_upd.frame        = i_entry.frame;
            o_upd.uses         = i_entry.uses + 1'b1;
            o_upd.counts       = counts_inc;
            o_upd.entry_we     = 1'b1;
            o_upd.cnt_we       = 1'b1;
        end else begin
            o_upd.status       = ST_FAULT;
            o_upd.entry.valid  = 1'b1;
            o_upd.entry.frame  = i_next_free[FRAME_W-1:0];
            o_upd.entry.uses   = USE_W'(1);
            o_upd.frame        = i_next_free[FRAME_W-1:0];
            o_upd.uses         = USE_W'(1);
            o_upd.counts       = counts_inc;
            o_upd.entry_we     = 1'b1;
            o_upd.cnt_we       = 1'b1;
            o_upd.alloc        = 1'b1;
        end
    end

endmodule

// ===== src/demand_paging_page_table_core.sv =====
// Top level of the demand paging page table with bump frame allocation.
//
//  channel  | dir | payload                                                  | accepted
//  i_req    | in  | process_id, virtual_page                                 | valid & ready
//  o_rsp    | out | status, frame_number, use_count, process_faults, refs   | valid & ready
//  i_cfg    | in  | data = num_processes                                     | valid & ready
//
// Each reference reads the table and counter RAMs in the accept cycle, and they
// are written back in the lookup state.
// After reset a clearing pass writes every table entry once
// (MAX_PROCESSES * PAGES_PER_PROCESS entries, 2048 by default); no reference is
// taken meanwhile, configuration writes are. A stalled output holds the lookup
// cycle; the output register lets the next reference in while a result waits.
`timescale 1ns / 1ps
module demand_paging_page_table_core
    import dpt_pkg::*;
#(
    parameter int MAX_PROCESSES     = 32,
    parameter int PAGES_PER_PROCESS = 64,
    parameter int TOTAL_FRAMES      = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dpt_in_if.sink     i_req,
    dpt_out_if.source  o_rsp,
    dpt_cfg_if.sink    i_cfg
);

    localparam int DEPTH   = MAX_PROCESSES * PAGES_PER_PROCESS;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int PID_AW  = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int PAGE_AW = $clog2(PAGES_PER_PROCESS);
    localparam int ENTRY_W = $bits(t_entry);
    localparam int CNT_W   = $bits(t_counts);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP
    } t_state;

    t_state              r_state;
    logic [ADDR_W-1:0]   r_clr_addr;
    logic [ADDR_W-1:0]   r_idx;
    logic [PID_AW-1:0]   r_pid;
    logic [FREE_W-1:0]   r_next_free;
    logic                r_halted;
    logic                r_out_valid;
    t_status             r_status;
    logic [FRAME_W-1:0]  r_frame;
    logic [USE_W-1:0]    r_uses;
    t_counts             r_counts;

    logic                req_fire;
    logic                finish;
    logic                clearing;
    logic [PID_AW-1:0]   pid_mod;
    logic [PAGE_AW-1:0]  page_mod;
    logic [ADDR_W-1:0]   idx;
    t_entry              entry_rd;
    t_counts             cnt_rd;
    t_update             upd;
    logic                ent_we;
    logic [ADDR_W-1:0]   ent_wr_addr;
    logic [ENTRY_W-1:0]  ent_wr_data;
    logic                cnt_we;
    logic [PID_AW-1:0]   cnt_wr_addr;
    logic [CNT_W-1:0]    cnt_wr_data;

    // Handshakes
    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == S_IDLE);
    assign req_fire    = i_req.valid && i_req.ready;
    assign clearing    = (r_state == S_CLEAR);
    assign finish      = (r_state == S_LOOKUP) && (!r_out_valid || o_rsp.ready);

    // Fold process and page into range through small constant tables
    always_comb begin
        pid_mod  = '0;
        page_mod = '0;
        for (int k = 0; k < 2 ** PID_W; k++) begin
            if (i_req.process_id == PID_W'(k)) begin
                pid_mod = PID_AW'(k % MAX_PROCESSES);
            end
        end
        for (int k = 0; k < 2 ** PAGE_W; k++) begin
            if (i_req.virtual_page == PAGE_W'(k)) begin
                page_mod = PAGE_AW'(k % PAGES_PER_PROCESS);
            end
        end
    end

    assign idx = ADDR_W'(ADDR_W'(pid_mod) * ADDR_W'(PAGES_PER_PROCESS)) + ADDR_W'(page_mod);

    // Page table memory
    assign ent_we      = clearing || (finish && upd.entry_we);
    assign ent_wr_addr = clearing ? r_clr_addr : r_idx;
    assign ent_wr_data = clearing ? '0 : upd.entry;

    dpt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (ent_we),
        .i_wr_addr (ent_wr_addr),
        .i_wr_data (ent_wr_data),
        .i_re      (req_fire),
        .i_rd_addr (idx),
        .o_rd_data (entry_rd)
    );

    // Per-process counter memory, cleared by the same pass
    assign cnt_we      = (clearing && (r_clr_addr < ADDR_W'(MAX_PROCESSES))) ||
                         (finish && upd.cnt_we);
    assign cnt_wr_addr = clearing ? r_clr_addr[PID_AW-1:0] : r_pid;
    assign cnt_wr_data = clearing ? '0 : upd.counts;

    dpt_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_PROCESSES)
    ) u_counts (
        .i_clk     (i_clk),
        .i_we      (cnt_we),
        .i_wr_addr (cnt_wr_addr),
        .i_wr_data (cnt_wr_data),
        .i_re      (req_fire),
        .i_rd_addr (pid_mod),
        .o_rd_data (cnt_rd)
    );

    // Modify step
    dpt_update #(
        .TOTAL_FRAMES (TOTAL_FRAMES)
    ) u_update (
        .i_halted    (r_halted),
        .i_next_free (r_next_free),
        .i_entry     (entry_rd),
        .i_counts    (cnt_rd),
        .o_upd       (upd)
    );

    // Sequencer, allocator state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_next_free <= '0;
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the result once taken
            if (o_rsp.ready && !finish) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (req_fire) begin
                        r_idx   <= idx;
                        r_pid   <= pid_mod;
                        r_state <= S_LOOKUP;
                    end
                end
                S_LOOKUP: begin
                    if (finish) begin
                        r_out_valid <= 1'b1;
                        r_status    <= upd.status;
                        r_frame     <= upd.frame;
                        r_uses      <= upd.uses;
                        r_counts    <= upd.counts;
                        if (upd.halt_set) begin
                            r_halted <= 1'b1;
                        end
                        if (upd.alloc && !(i_cfg.valid && i_cfg.ready)) begin
                            r_next_free <= r_next_free + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            // reload the bump pointer past the page-table frames
            if (i_cfg.valid && i_cfg.ready) begin
                r_next_free <= FREE_W'(i_cfg.data) << FRAMES_SHIFT;
            end
        end
    end

    assign o_rsp.valid              = r_out_valid;
    assign o_rsp.status             = r_status;
    assign o_rsp.frame_number       = r_frame;
    assign o_rsp.use_count          = r_uses;
    assign o_rsp.process_faults     = r_counts.faults;
    assign o_rsp.process_references = r_counts.refs;

`ifndef NO_ASSERTIONS
    // Halt is permanent until reset
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halt flag cleared");

    // An out-of-memory result carries no mapping
    a_oom_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status == ST_OOM)) |-> ((r_frame == '0) && (r_uses == '0)))
        else $error("out-of-memory result with mapping");

    // No table update once halted
    a_no_write_halted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (finish && r_halted) |-> (!upd.entry_we && !upd.cnt_we && !upd.alloc))
        else $error("state changed while halted");

    // The bump pointer moves only by allocation or configuration
    a_free_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!(i_cfg.valid && i_cfg.ready) && !(finish && upd.alloc))
            |=> $stable(r_next_free))
        else $error("free frame pointer moved unexpectedly");
`endif

endmodule

// ===== test/demand_paging_page_table_core_tb.sv =====
// Testbench of the demand paging page table core: directed, use-count wrap, random and halt tests.
`timescale 1ns / 1ps
module demand_paging_page_table_core_tb;
    import dpt_pkg::*;

    localparam int MAX_PROCS      = 32;
    localparam int PAGES          = 64;
    localparam int TABLE_DEPTH    = MAX_PROCS * PAGES;
    localparam int TOTAL_FRAMES   = 256;
    localparam int USE_WRAP_ITEMS = 260;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 110;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int PRINT_LIMIT    = 40;

    // Expected outcome of one page reference
    typedef struct {
        t_status            status;
        logic [FRAME_W-1:0] frame;
        logic [USE_W-1:0]   uses;
        logic [FAULT_W-1:0] faults;
        logic [REF_W-1:0]   refs;
    } t_lookup;

    logic i_clk = 1'b0;
    logic i_rst_n;

    dpt_in_if  req_if ();
    dpt_out_if rsp_if ();
    dpt_cfg_if cfg_if ();

    demand_paging_page_table_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    // Shadow page table, free frame counter and per-process statistics
    bit                 tbl_valid [TABLE_DEPTH];
    bit [FRAME_W-1:0]   tbl_frame [TABLE_DEPTH];
    bit [USE_W-1:0]     tbl_uses  [TABLE_DEPTH];
    bit [FREE_W-1:0]    next_frame;
    bit [FAULT_W-1:0]   fault_cnt [MAX_PROCS];
    bit [REF_W-1:0]     ref_cnt   [MAX_PROCS];
    bit                 oom_halted;
    bit [NPROC_W-1:0]   num_procs;
    int                 mapped_q [$];

    t_lookup pending_lookups [$];
    int      mismatch_count = 0;
    int      cycle_count    = 0;
    int      send_idle_pct  = 0;
    int      recv_idle_pct  = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Count cycles for the watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // Work out the outcome of one reference and advance the shadow state
    function automatic t_lookup lookup_page(input logic [PID_W-1:0] pid,
                                            input logic [PAGE_W-1:0] page);
        t_lookup r;
        int      idx;
        idx      = int'(pid) * PAGES + int'(page);
        r.status = ST_HIT;
        r.frame  = '0;
        r.uses   = '0;
        if (!oom_halted && !tbl_valid[idx] && next_frame >= TOTAL_FRAMES) begin
            oom_halted = 1'b1;
        end
        if (oom_halted) begin
            r.status = ST_OOM;
        end else if (tbl_valid[idx]) begin
            tbl_uses[idx] = tbl_uses[idx] + 1'b1;
            r.frame       = tbl_frame[idx];
            r.uses        = tbl_uses[idx];
            if (ref_cnt[pid] != REF_MAX) ref_cnt[pid]++;
        end else begin
            r.status       = ST_FAULT;
            tbl_valid[idx] = 1'b1;
            tbl_uses[idx]  = USE_W'(1);
            tbl_frame[idx] = next_frame[FRAME_W-1:0];
            r.frame        = tbl_frame[idx];
            r.uses         = USE_W'(1);
            next_frame     = next_frame + 1'b1;
            mapped_q.push_back(idx);
            if (fault_cnt[pid] != FAULT_MAX) fault_cnt[pid]++;
            if (ref_cnt[pid] != REF_MAX) ref_cnt[pid]++;
        end
        r.faults = fault_cnt[pid];
        r.refs   = ref_cnt[pid];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("MISMATCH cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
        end
        mismatch_count++;
    endtask

    task automatic check_result();
        t_lookup want;
        if (pending_lookups.size() == 0) begin
            report_mismatch("result with nothing pending, status", int'(rsp_if.status), -1);
        end else begin
            want = pending_lookups.pop_front();
            if (rsp_if.status !== want.status)
                report_mismatch("status", int'(rsp_if.status), int'(want.status));
            if (rsp_if.frame_number !== want.frame)
                report_mismatch("frame_number", int'(rsp_if.frame_number), int'(want.frame));
            if (rsp_if.use_count !== want.uses)
                report_mismatch("use_count", int'(rsp_if.use_count), int'(want.uses));
            if (rsp_if.process_faults !== want.faults)
                report_mismatch("process_faults", int'(rsp_if.process_faults),
                                int'(want.faults));
            if (rsp_if.process_references !== want.refs)
                report_mismatch("process_references", int'(rsp_if.process_references),
                                int'(want.refs));
        end
    endtask

    // Check each accepted result and stall the output at random
    always @(posedge i_clk) begin
        if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) check_result();
        rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Send one reference; valid stays high after the transaction unless a gap follows
    task automatic send_ref(input logic [PID_W-1:0] pid, input logic [PAGE_W-1:0] page);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.process_id   <= pid;
        req_if.virtual_page <= page;
        @(posedge i_clk);
        while (req_if.ready !== 1'b1) @(posedge i_clk);
        pending_lookups.push_back(lookup_page(pid, page));
    endtask

    // Drop the request and hold until every pending result has arrived
    task automatic drain_lookups();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_lookups.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write num_processes once the block is idle; it reloads the free frame counter
    task automatic write_num_processes(input logic [NPROC_W-1:0] value);
        drain_lookups();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        @(posedge i_clk);
        while (cfg_if.ready !== 1'b1) @(posedge i_clk);
        num_procs    = value;
        next_frame   = FREE_W'(num_procs) << FRAMES_SHIFT;
        cfg_if.valid <= 1'b0;
    endtask

    task automatic send_index(input int idx);
        send_ref(PID_W'(idx / PAGES), PAGE_W'(idx % PAGES));
    endtask

    function automatic int pick_mapped();
        return mapped_q[$urandom_range(0, mapped_q.size() - 1)];
    endfunction

    function automatic int pick_unmapped();
        int idx;
        do idx = $urandom_range(0, TABLE_DEPTH - 1); while (tbl_valid[idx]);
        return idx;
    endfunction

    // Field extremes, hits after faults, reload of the free counter, full table area
    task automatic test_directed_lookups();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_num_processes(0);
        send_ref(0, 0);
        send_ref(0, 0);
        send_ref(31, 63);
        send_ref(31, 63);
        send_ref(21, 42);
        send_ref(10, 21);
        send_ref(0, 63);
        send_ref(31, 0);
        // reload the free counter after frames were handed out
        write_num_processes(2);
        send_ref(21, 42);
        send_ref(3, 5);
        // no frame left at all: hits only
        write_num_processes(32);
        send_ref(0, 0);
        send_ref(10, 21);
    endtask

    // Hammer one entry until its use count wraps past 255
    task automatic test_use_wrap();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_num_processes(4);
        for (int i = 0; i < USE_WRAP_ITEMS; i++) begin
            send_ref(12, 33);
        end
    endtask

    task automatic run_random_phase(input logic [NPROC_W-1:0] nproc, input int s_pct,
                                    input int r_pct);
        int idx;
        write_num_processes(nproc);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            // mostly revisit mapped pages, otherwise touch anywhere
            if (mapped_q.size() != 0 && $urandom_range(0, 99) < 60) idx = pick_mapped();
            else idx = $urandom_range(0, TABLE_DEPTH - 1);
            // keep clear of the halt while frames are exhausted
            if (!tbl_valid[idx] && next_frame >= TOTAL_FRAMES) idx = pick_mapped();
            send_index(idx);
            if (i == PHASE_ITEMS / 2 || $urandom_range(0, 99) == 0) drain_lookups();
        end
    endtask

    // Random traffic across several settings and idling patterns
    task automatic test_random_traffic();
        logic [NPROC_W-1:0] nproc;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: nproc = 32;
                2: nproc = 63;
                5: nproc = 0;
                default: nproc = NPROC_W'($urandom_range(1, 31));
            endcase
            if (p < 2)      run_random_phase(nproc, 26, 45);
            else if (p < 4) run_random_phase(nproc, 45, 26);
            else            run_random_phase(nproc, 0, 0);
        end
    endtask

    // Exhaust the last frames, then every reference reports out of memory
    task automatic test_out_of_memory();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_num_processes(31);
        for (int i = 0; i < 8; i++) begin
            send_index(pick_unmapped());
        end
        send_index(pick_unmapped());
        send_ref(0, 0);
        send_index(pick_unmapped());
        send_ref(12, 33);
        // register writes leave the halt in place
        write_num_processes(63);
        send_ref(31, 63);
        write_num_processes(0);
        send_ref(0, 0);
        send_index(pick_unmapped());
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        req_if.valid    <= 1'b0;
        req_if.process_id   <= '0;
        req_if.virtual_page <= '0;
        cfg_if.valid    <= 1'b0;
        cfg_if.data     <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_lookups();
        test_use_wrap();
        test_random_traffic();
        test_out_of_memory();
        drain_lookups();

        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
